// ----- sv/ascii_bitmap_stream_parser_defines.svh -----
// Assertion macros shared by the ascii_bitmap_stream_parser RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASCII_BITMAP_STREAM_PARSER_DEFINES_SVH
`define ASCII_BITMAP_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ABPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/abps_pkg.sv -----
// Package for the ascii_bitmap_stream_parser: item types, byte classes,
// parser phases and result codes. No dependencies.
package abps_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH    = 2;

  // Result kinds
  localparam logic [2:0] K_SIZE       = 3'd0;
  localparam logic [2:0] K_PIXEL      = 3'd1;
  localparam logic [2:0] K_SUCCESS    = 3'd2;
  localparam logic [2:0] K_BAD_SIG    = 3'd3;
  localparam logic [2:0] K_BAD_HEADER = 3'd4;
  localparam logic [2:0] K_BAD_DATA   = 3'd5;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam int         RADIX    = 10;

  typedef enum logic [3:0] {
    PH_SIG_P   = 4'd0,
    PH_SIG_ONE = 4'd1,
    PH_SIG_END = 4'd2,
    PH_SIG_LF  = 4'd3,
    PH_W_PRE   = 4'd4,
    PH_W_NUM   = 4'd5,
    PH_H_PRE   = 4'd6,
    PH_H_NUM   = 4'd7,
    PH_PIXEL   = 4'd8,
    PH_DELIM   = 4'd9,
    PH_SKIP    = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        pixel_value;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width_out;
    logic [12:0] image_height_out;
  } out_item_t;

  // Classified byte handed from the front to the back
  typedef struct packed {
    logic       eof;
    logic       is_p;
    logic       is_one;
    logic       digit;
    logic [3:0] dval;
    logic       bit01;
    logic       blank;
    logic       space;
    logic       lf;
    logic       cr;
    logic       nul;
    logic       plus;
    logic       minus;
  } byte_class_t;

endpackage

// ----- sv/abps_front.sv -----
// Front part of the parser: accepts input items and classifies each byte.
// Depends on abps_pkg.
module abps_front (
  input  logic                  rst_n,
  input  abps_pkg::in_item_t    in_data,
  input  logic                  in_valid,
  input  logic                  q_full,
  output logic                  in_ready,
  output logic                  q_push,
  output abps_pkg::byte_class_t q_class
);
  import abps_pkg::*;

  logic [7:0] b;

  // Hold in_ready low through reset so no item is taken and then dropped
  assign b        = in_data.data_byte;
  assign in_ready = rst_n && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_class        = '0;
    q_class.eof    = (in_data.op == OP_EOF);
    q_class.is_p   = (b == CH_P);
    q_class.is_one = (b == CH_ONE);
    q_class.digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    q_class.dval   = 4'(b - CH_ZERO);
    q_class.bit01  = (b == CH_ZERO) || (b == CH_ONE);
    q_class.blank  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
                     (b == CH_FF) || (b == CH_CR);
    q_class.space  = (b == CH_SPACE);
    q_class.lf     = (b == CH_LF);
    q_class.cr     = (b == CH_CR);
    q_class.nul    = (b == CH_NUL);
    q_class.plus   = (b == CH_PLUS);
    q_class.minus  = (b == CH_MINUS);
  end

endmodule

// ----- sv/abps_queue.sv -----
// Short register queue between the front and back of the parser.
// Depends on abps_pkg and ascii_bitmap_stream_parser_defines.svh.
`include "ascii_bitmap_stream_parser_defines.svh"
module abps_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  abps_pkg::byte_class_t push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output abps_pkg::byte_class_t head
);
  import abps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  byte_class_t      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `ABPS_ASSERT_NOW(a_q_no_overfill, clk, rst_n, push, !full, "queue push while full")
  `ABPS_ASSERT_NOW(a_q_no_underrun, clk, rst_n, pop, not_empty, "queue pop while empty")
  `ABPS_ASSERT_NEXT(a_q_count, clk, rst_n, push && !pop, count_r != '0, "queue count lost push")

endmodule

// ----- sv/abps_back.sv -----
// Back part of the parser: phase machine over classified bytes and the
// result register. Depends on abps_pkg and ascii_bitmap_stream_parser_defines.svh.
`include "ascii_bitmap_stream_parser_defines.svh"
module abps_back #(
  parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  abps_pkg::byte_class_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output abps_pkg::out_item_t   out_data
);
  import abps_pkg::*;

  localparam int MAX_NUM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int NUM_W   = $clog2(MAX_NUM + 1);
  localparam int MUL_W   = NUM_W + 4;
  localparam int CMP_W   = NUM_W + 1;
  localparam int COL_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);

  phase_t           phase_r, phase_nxt;
  logic [NUM_W-1:0] width_r, width_nxt;
  logic [NUM_W-1:0] height_r, height_nxt;
  logic [NUM_W-1:0] accum_r, accum_nxt;
  logic             ovf_r, ovf_nxt;
  logic             seen_r, seen_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, res;
  logic             produce;

  logic             advance;
  logic             last_col, last_row, num_ok, in_height;
  logic [MUL_W-1:0] limit, mac;

  assign advance   = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_height = (phase_r == PH_H_PRE) || (phase_r == PH_H_NUM);
  assign limit     = in_height ? MUL_W'(MAX_HEIGHT) : MUL_W'(MAX_WIDTH);
  assign mac       = MUL_W'(accum_r) * MUL_W'(RADIX) + MUL_W'(q_head.dval);
  assign last_col  = (CMP_W'(col_r) + 1'b1) >= CMP_W'(width_r);
  assign last_row  = (CMP_W'(row_r) + 1'b1) >= CMP_W'(height_r);
  assign num_ok    = !ovf_r && (accum_r != '0);

  always_comb begin
    phase_nxt  = phase_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    accum_nxt  = accum_r;
    ovf_nxt    = ovf_r;
    seen_nxt   = seen_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    produce    = 1'b0;
    res        = '0;

    if (q_head.eof) begin
      // Report by phase, then fall back to the reset state
      case (phase_r)
        PH_SIG_P, PH_SIG_ONE, PH_SIG_END, PH_SIG_LF: begin
          produce  = 1'b1;
          res.kind = K_BAD_SIG;
        end
        PH_W_PRE, PH_W_NUM, PH_H_PRE, PH_H_NUM: begin
          produce  = 1'b1;
          res.kind = K_BAD_HEADER;
        end
        PH_PIXEL, PH_SKIP: begin
          produce  = 1'b1;
          res.kind = K_BAD_DATA;
        end
        PH_DELIM: begin
          produce  = 1'b1;
          res.kind = (last_col && last_row) ? K_SUCCESS : K_BAD_DATA;
        end
        default: begin
          produce = 1'b0;
        end
      endcase
      phase_nxt  = PH_SIG_P;
      width_nxt  = '0;
      height_nxt = '0;
      accum_nxt  = '0;
      ovf_nxt    = 1'b0;
      seen_nxt   = 1'b0;
      col_nxt    = '0;
      row_nxt    = '0;
    end else begin
      case (phase_r)
        PH_SIG_P: begin
          if (q_head.is_p) begin
            phase_nxt = PH_SIG_ONE;
          end else begin
            phase_nxt = PH_DONE;
            produce   = 1'b1;
            res.kind  = K_BAD_SIG;
          end
        end
        PH_SIG_ONE: begin
          if (q_head.is_one) begin
            phase_nxt = PH_SIG_END;
          end else begin
            phase_nxt = PH_DONE;
            produce   = 1'b1;
            res.kind  = K_BAD_SIG;
          end
        end
        PH_SIG_END, PH_SIG_LF: begin
          if (q_head.lf) begin
            accum_nxt = '0;
            ovf_nxt   = 1'b0;
            seen_nxt  = 1'b0;
            phase_nxt = PH_W_PRE;
          end else if (q_head.cr && phase_r == PH_SIG_END) begin
            phase_nxt = PH_SIG_LF;
          end else begin
            phase_nxt = PH_DONE;
            produce   = 1'b1;
            res.kind  = K_BAD_SIG;
          end
        end
        PH_W_PRE, PH_H_PRE: begin
          if (q_head.blank) begin
            phase_nxt = phase_r;
          end else if (q_head.plus || q_head.minus || q_head.digit) begin
            phase_nxt = (phase_r == PH_W_PRE) ? PH_W_NUM : PH_H_NUM;
            if (q_head.minus) begin
              ovf_nxt = 1'b1;
            end
            if (q_head.digit) begin
              seen_nxt = 1'b1;
              if (!ovf_r) begin
                if (mac > limit) begin
                  ovf_nxt = 1'b1;
                end else begin
                  accum_nxt = NUM_W'(mac);
                end
              end
            end
          end else begin
            phase_nxt = PH_DONE;
            produce   = 1'b1;
            res.kind  = K_BAD_HEADER;
          end
        end
        PH_W_NUM, PH_H_NUM: begin
          if (q_head.digit) begin
            seen_nxt = 1'b1;
            if (!ovf_r) begin
              if (mac > limit) begin
                ovf_nxt = 1'b1;
              end else begin
                accum_nxt = NUM_W'(mac);
              end
            end
          end else if (phase_r == PH_W_NUM && seen_r && q_head.space && num_ok) begin
            width_nxt = accum_r;
            accum_nxt = '0;
            ovf_nxt   = 1'b0;
            seen_nxt  = 1'b0;
            phase_nxt = PH_H_PRE;
          end else if (phase_r == PH_H_NUM && seen_r && (q_head.lf || q_head.cr) &&
                       num_ok) begin
            height_nxt           = accum_r;
            col_nxt              = '0;
            row_nxt              = '0;
            phase_nxt            = q_head.lf ? PH_PIXEL : PH_SKIP;
            produce              = 1'b1;
            res.kind             = K_SIZE;
            res.image_width_out  = 13'(width_r);
            res.image_height_out = 13'(accum_r);
          end else begin
            phase_nxt = PH_DONE;
            produce   = 1'b1;
            res.kind  = K_BAD_HEADER;
          end
        end
        PH_PIXEL: begin
          produce = 1'b1;
          if (q_head.bit01) begin
            phase_nxt       = PH_DELIM;
            res.kind        = K_PIXEL;
            res.pixel_value = q_head.dval[0];
            res.column      = 12'(col_r);
            res.row         = 12'(row_r);
          end else begin
            phase_nxt = PH_DONE;
            res.kind  = K_BAD_DATA;
          end
        end
        PH_DELIM: begin
          if (q_head.space && !last_col) begin
            col_nxt   = col_r + 1'b1;
            phase_nxt = PH_PIXEL;
          end else if ((q_head.space || q_head.lf || q_head.cr || q_head.nul) &&
                       last_col) begin
            // End of row: success on the last row, else start the next one
            if (last_row) begin
              phase_nxt = PH_DONE;
              produce   = 1'b1;
              res.kind  = K_SUCCESS;
            end else begin
              row_nxt   = row_r + 1'b1;
              col_nxt   = '0;
              phase_nxt = q_head.lf ? PH_PIXEL : PH_SKIP;
            end
          end else begin
            phase_nxt = PH_DONE;
            produce   = 1'b1;
            res.kind  = K_BAD_DATA;
          end
        end
        PH_SKIP: begin
          if (q_head.lf) begin
            phase_nxt = PH_PIXEL;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = produce;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG_P;
      width_r     <= '0;
      height_r    <= '0;
      accum_r     <= '0;
      ovf_r       <= 1'b0;
      seen_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r  <= phase_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        accum_r  <= accum_nxt;
        ovf_r    <= ovf_nxt;
        seen_r   <= seen_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_data_r <= res;
    end
  end

  `ABPS_ASSERT_NOW(a_pop_needs_room, clk, rst_n, q_pop, !out_valid_r || out_ready, "pop with result stuck")
  `ABPS_ASSERT_NOW(a_col_in_range, clk, rst_n, phase_r == PH_DELIM, CMP_W'(col_r) < CMP_W'(width_r), "column past width")
  `ABPS_ASSERT_NOW(a_row_in_range, clk, rst_n, phase_r == PH_DELIM, CMP_W'(row_r) < CMP_W'(height_r), "row past height")
  `ABPS_ASSERT_NEXT(a_size_enters_data, clk, rst_n, advance && produce && res.kind == K_SIZE, phase_r == PH_PIXEL || phase_r == PH_SKIP, "size result without data phase")

endmodule

// ----- sv/ascii_bitmap_stream_parser.sv -----
// Top level of the ASCII P1 bitmap stream parser.
// Depends on abps_pkg, abps_front, abps_queue and abps_back.
//
//  Port group | Direction | Handshake            | Payload
//  in_        | input     | in_valid / in_ready  | in_data   (abps_pkg::in_item_t)
//  out_       | output    | out_valid / out_ready| out_data  (abps_pkg::out_item_t)
//
// One item per cycle while out_ready holds: each byte passes through the parser phase
// machine, whose multiply-by-ten accumulate and row/column compares set the path.
// An accepted byte is registered in a queue slot, its result in the result register.
// Reset is synchronous on rst_n low and holds in_ready low; no clearing pass is needed.
// An output stall holds the result register; the two-entry queue keeps taking
// items until it fills, then in_ready drops.
module ascii_bitmap_stream_parser #(
  parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  abps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output abps_pkg::out_item_t out_data
);
  import abps_pkg::*;

  // Front to back link
  byte_class_t push_class;
  byte_class_t head_class;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;

  // Classify the byte and push it while the queue has room
  abps_front u_front (
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_ready (in_ready),
    .q_push   (q_push),
    .q_class  (push_class)
  );

  // Decouple accept from parsing so each side can stall on its own
  abps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_class),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_class)
  );

  // Advance the phase machine and hold results until taken
  abps_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (head_class),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the ASCII P1 bitmap stream parser.
// Feeds directed and random bitmap files and checks every result item against a byte-level
// parser model or a typed expectation. Depends on abps_pkg and ascii_bitmap_stream_parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abps_pkg::*;

  localparam int          IDLE_PCT     = 26;     // chance per cycle that a side idles
  localparam int          HOLD_CYCLES  = 120;    // long result-side hold-off
  localparam int          DRAIN_CYCLES = 10;     // margin after the last result for any stray one
  localparam int unsigned RANDOM_ITEMS = 1420;
  localparam int unsigned WIDTH_LIMIT  = DEF_MAX_WIDTH;
  localparam int unsigned HEIGHT_LIMIT = DEF_MAX_HEIGHT;

  // Where a directed row takes its expectation from
  typedef enum logic [1:0] {
    EXP_MODEL,  // ask the parser model
    EXP_NONE,   // no result item
    EXP_ITEM    // the item typed into the row
  } exp_src_t;

  typedef struct packed {
    in_item_t  stim;
    exp_src_t  src;
    out_item_t want;
  } directed_row_t;

  localparam out_item_t BAD_SIG_ITEM  = '{K_BAD_SIG, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0};
  localparam out_item_t BAD_HDR_ITEM  = '{K_BAD_HEADER, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0};
  localparam out_item_t BAD_DATA_ITEM = '{K_BAD_DATA, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0};

  // Directed files:
  //  - end of file straight after reset
  //  - CR LF signature, tab and plus before the largest legal width, size line ended by CR,
  //    skipped byte with all bits set, two pixels of a row that is never finished
  //  - negative width caught at the space that ends it, then bytes ignored until end of file
  //  - wrong first signature byte
  localparam directed_row_t DIRECTED [30] = '{
    '{'{OP_EOF,  CH_NUL},   EXP_ITEM,  BAD_SIG_ITEM},
    '{'{OP_BYTE, CH_P},     EXP_NONE,  '0},
    '{'{OP_BYTE, CH_ONE},   EXP_NONE,  '0},
    '{'{OP_BYTE, CH_CR},    EXP_NONE,  '0},
    '{'{OP_BYTE, CH_LF},    EXP_NONE,  '0},
    '{'{OP_BYTE, CH_TAB},   EXP_NONE,  '0},
    '{'{OP_BYTE, CH_PLUS},  EXP_NONE,  '0},
    '{'{OP_BYTE, "4"},      EXP_NONE,  '0},
    '{'{OP_BYTE, CH_ZERO},  EXP_NONE,  '0},
    '{'{OP_BYTE, CH_NINE},  EXP_NONE,  '0},
    '{'{OP_BYTE, "6"},      EXP_NONE,  '0},
    '{'{OP_BYTE, CH_SPACE}, EXP_NONE,  '0},
    '{'{OP_BYTE, CH_ONE},   EXP_NONE,  '0},
    '{'{OP_BYTE, CH_CR},    EXP_ITEM,  '{K_SIZE, 1'b0, 12'd0, 12'd0, 13'd4096, 13'd1}},
    '{'{OP_BYTE, 8'hFF},    EXP_NONE,  '0},
    '{'{OP_BYTE, CH_LF},    EXP_NONE,  '0},
    '{'{OP_BYTE, CH_ONE},   EXP_ITEM,  '{K_PIXEL, 1'b1, 12'd0, 12'd0, 13'd0, 13'd0}},
    '{'{OP_BYTE, CH_SPACE}, EXP_MODEL, '0},
    '{'{OP_BYTE, CH_ZERO},  EXP_MODEL, '0},
    '{'{OP_EOF,  8'hA5},    EXP_ITEM,  BAD_DATA_ITEM},
    '{'{OP_BYTE, CH_P},     EXP_NONE,  '0},
    '{'{OP_BYTE, CH_ONE},   EXP_NONE,  '0},
    '{'{OP_BYTE, CH_LF},    EXP_NONE,  '0},
    '{'{OP_BYTE, CH_MINUS}, EXP_NONE,  '0},
    '{'{OP_BYTE, "7"},      EXP_NONE,  '0},
    '{'{OP_BYTE, CH_SPACE}, EXP_ITEM,  BAD_HDR_ITEM},
    '{'{OP_BYTE, CH_P},     EXP_NONE,  '0},
    '{'{OP_EOF,  CH_NUL},   EXP_NONE,  '0},
    '{'{OP_BYTE, "Q"},      EXP_ITEM,  BAD_SIG_ITEM},
    '{'{OP_EOF,  8'h5A},    EXP_NONE,  '0}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Result items still owed by the block, oldest first
  out_item_t   expected_results[$];
  // Bytes of the file being built
  in_item_t    file_bytes[$];
  int          error_count  = 0;
  int unsigned parsed_items = 0;
  bit          hold_off_req = 1'b0;
  bit          steady_flow  = 1'b0;

  // Parser model state
  phase_t      bm_phase;
  logic [12:0] bm_width;
  logic [12:0] bm_height;
  logic [12:0] bm_accum;
  logic        bm_over;
  logic        bm_digits;
  logic [11:0] bm_col;
  logic [11:0] bm_row;

  ascii_bitmap_stream_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs or withholds a result
  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic void clear_number();
    bm_accum  = '0;
    bm_over   = 1'b0;
    bm_digits = 1'b0;
  endfunction

  // Back to the state of a fresh file: after reset and after every end of file
  function automatic void reset_parser_model();
    bm_phase  = PH_SIG_P;
    bm_width  = '0;
    bm_height = '0;
    bm_col    = '0;
    bm_row    = '0;
    clear_number();
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Accumulate one decimal digit; once the value passes the limit, freeze it and flag it
  function automatic void take_digit(input logic [7:0] b, input int unsigned limit);
    int unsigned next_val;
    next_val  = bm_accum * RADIX + (b - CH_ZERO);
    bm_digits = 1'b1;
    if (!bm_over) begin
      if (next_val > limit) bm_over = 1'b1;
      else bm_accum = 13'(next_val);
    end
  endfunction

  function automatic bit size_ok();
    return !bm_over && bm_accum != 0;
  endfunction

  // Report a failure and park until end of file
  function automatic bit fail_parse(input logic [2:0] kind, output out_item_t res);
    res      = '0;
    res.kind = kind;
    bm_phase = PH_DONE;
    return 1'b1;
  endfunction

  // Advance the model by one item; return 1 with the result item when one is due
  function automatic bit predict_parse(input in_item_t stim, output out_item_t res);
    logic [7:0]  b;
    int unsigned limit;
    bit          last_col;
    bit          found;
    b     = stim.data_byte;
    res   = '0;
    found = 1'b0;
    if (stim.op == OP_EOF) begin
      // End of file: verdict depends on where the parse stands, then start over
      found = 1'b1;
      if (bm_phase <= PH_SIG_LF) res.kind = K_BAD_SIG;
      else if (bm_phase <= PH_H_NUM) res.kind = K_BAD_HEADER;
      else if (bm_phase == PH_DELIM && bm_col + 1 >= bm_width && bm_row + 1 >= bm_height)
        res.kind = K_SUCCESS;
      else if (bm_phase <= PH_SKIP) res.kind = K_BAD_DATA;
      else found = 1'b0;
      reset_parser_model();
      return found;
    end
    case (bm_phase)
      PH_SIG_P: begin
        if (b == CH_P) bm_phase = PH_SIG_ONE;
        else found = fail_parse(K_BAD_SIG, res);
      end
      PH_SIG_ONE: begin
        if (b == CH_ONE) bm_phase = PH_SIG_END;
        else found = fail_parse(K_BAD_SIG, res);
      end
      PH_SIG_END, PH_SIG_LF: begin
        if (b == CH_LF) begin
          clear_number();
          bm_phase = PH_W_PRE;
        end else if (b == CH_CR && bm_phase == PH_SIG_END) begin
          bm_phase = PH_SIG_LF;
        end else begin
          found = fail_parse(K_BAD_SIG, res);
        end
      end
      PH_W_PRE, PH_H_PRE: begin
        // Skip blanks, take one sign or the first digit
        limit = (bm_phase == PH_W_PRE) ? WIDTH_LIMIT : HEIGHT_LIMIT;
        if (!(b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR)) begin
          if (b == CH_PLUS || b == CH_MINUS || is_digit(b)) begin
            if (b == CH_MINUS) bm_over = 1'b1;
            if (is_digit(b)) take_digit(b, limit);
            bm_phase = (bm_phase == PH_W_PRE) ? PH_W_NUM : PH_H_NUM;
          end else begin
            found = fail_parse(K_BAD_HEADER, res);
          end
        end
      end
      PH_W_NUM: begin
        if (is_digit(b)) begin
          take_digit(b, WIDTH_LIMIT);
        end else if (!bm_digits || b != CH_SPACE || !size_ok()) begin
          found = fail_parse(K_BAD_HEADER, res);
        end else begin
          bm_width = bm_accum;
          clear_number();
          bm_phase = PH_H_PRE;
        end
      end
      PH_H_NUM: begin
        if (is_digit(b)) begin
          take_digit(b, HEIGHT_LIMIT);
        end else if (!bm_digits || (b != CH_LF && b != CH_CR) || !size_ok()) begin
          found = fail_parse(K_BAD_HEADER, res);
        end else begin
          bm_height = bm_accum;
          bm_col    = '0;
          bm_row    = '0;
          bm_phase  = (b == CH_LF) ? PH_PIXEL : PH_SKIP;
          res.kind             = K_SIZE;
          res.image_width_out  = bm_width;
          res.image_height_out = bm_height;
          found = 1'b1;
        end
      end
      PH_PIXEL: begin
        if (b != CH_ZERO && b != CH_ONE) begin
          found = fail_parse(K_BAD_DATA, res);
        end else begin
          bm_phase        = PH_DELIM;
          res.kind        = K_PIXEL;
          res.pixel_value = b[0];
          res.column      = bm_col;
          res.row         = bm_row;
          found = 1'b1;
        end
      end
      PH_DELIM: begin
        last_col = (bm_col + 1 >= bm_width);
        if (b == CH_SPACE && !last_col) begin
          bm_col   = bm_col + 1'b1;
          bm_phase = PH_PIXEL;
        end else if (b == CH_SPACE || ((b == CH_LF || b == CH_CR || b == CH_NUL) && last_col))
        begin
          // Row complete: either the image is done or move down a row
          if (bm_row + 1 >= bm_height) begin
            res.kind = K_SUCCESS;
            bm_phase = PH_DONE;
            found    = 1'b1;
          end else begin
            bm_row   = bm_row + 1'b1;
            bm_col   = '0;
            bm_phase = (b != CH_LF) ? PH_SKIP : PH_PIXEL;
          end
        end else begin
          found = fail_parse(K_BAD_DATA, res);
        end
      end
      PH_SKIP: begin
        if (b == CH_LF) bm_phase = PH_PIXEL;
      end
      default: ;
    endcase
    return found;
  endfunction

  // ---------------------------------------------------------------------------
  // File builders
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] value);
    in_item_t it;
    it.op        = OP_BYTE;
    it.data_byte = value;
    file_bytes.push_back(it);
  endfunction

  function automatic void push_text(input string text);
    for (int i = 0; i < text.len(); i++) push_byte(text[i]);
  endfunction

  // Size field: optional blanks, optional sign, optional leading zero, then the digits
  function automatic void push_number(input int unsigned value);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 4))
          0: push_byte(CH_SPACE);
          1: push_byte(CH_TAB);
          2: push_byte(CH_VT);
          3: push_byte(CH_FF);
          default: push_byte(CH_CR);
        endcase
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) push_byte(CH_PLUS);
    else if (pick < 17) push_byte(CH_MINUS);
    if ($urandom_range(0, 99) < 10) push_byte(CH_ZERO);
    push_text($sformatf("%0d", value));
  endfunction

  // Line end: LF half the time; otherwise CR (or NUL / space on a pixel row) and junk up to LF
  function automatic void push_line_end(input bit data_row);
    int unsigned pick;
    logic [7:0]  junk;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      push_byte(CH_LF);
    end else begin
      if (!data_row || pick < 7) push_byte(CH_CR);
      else if (pick == 7) push_byte(CH_NUL);
      else push_byte(CH_SPACE);
      repeat ($urandom_range(0, 2)) begin
        junk = 8'($urandom_range(0, 255));
        if (junk == CH_LF) junk = CH_CR;
        push_byte(junk);
      end
      push_byte(CH_LF);
    end
  endfunction

  // Size values at and around the edges of the legal range
  function automatic int unsigned pick_extreme();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return WIDTH_LIMIT - 1;
      3, 4:    return WIDTH_LIMIT;
      5:       return WIDTH_LIMIT + 1;
      6:       return 9999;
      default: return 123456;
    endcase
  endfunction

  function automatic string show_result(input out_item_t r);
    return $sformatf("kind=%0d pix=%0d col=%0d row=%0d w=%0d h=%0d", r.kind, r.pixel_value,
                     r.column, r.row, r.image_width_out, r.image_height_out);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one item, idle at random outside the steady stretch, hold until taken
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t stim, output bit found, output out_item_t res);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= stim;
    do @(posedge clk); while (!in_ready);
    // Count every item the block has taken
    parsed_items++;
    found = predict_parse(stim, res);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, a long hold-off on request, no stalls in the steady stretch
  // ---------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // Hold the result side shut so the block fills and drops in_ready
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result item with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result: %s", show_result(out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind || out_data.pixel_value !== want.pixel_value ||
            out_data.column !== want.column || out_data.row !== want.row ||
            out_data.image_width_out !== want.image_width_out ||
            out_data.image_height_out !== want.image_height_out) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected %s, got %s", show_result(want),
                     show_result(out_data));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t    stim;
    out_item_t   res;
    bit          found;
    int unsigned shape;
    int unsigned img_w;
    int unsigned img_h;
    int unsigned rows;
    int unsigned cols;
    int unsigned spot;
    int unsigned file_count;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    reset_parser_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files: take the typed expectation where a row has one
    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].stim, found, res);
      if (DIRECTED[i].src == EXP_ITEM) expected_results.push_back(DIRECTED[i].want);
      else if (DIRECTED[i].src == EXP_MODEL && found) expected_results.push_back(res);
    end

    // Random files, mostly well formed with random content
    file_count = 0;
    while (parsed_items < RANDOM_ITEMS) begin
      if (file_count == 4 || file_count == 22) hold_off_req = 1'b1;
      if (file_count == 10 && expected_results.size() != 0) begin
        // Pause the input until everything in flight has come out
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      steady_flow = (file_count >= 10 && file_count < 17);

      file_bytes.delete();
      shape = $urandom_range(0, 99);
      if (shape < 6) begin
        // Pure noise, half of it behind a good signature
        if (shape < 3) push_text("P1");
        repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_text("P1");
        if ($urandom_range(0, 1)) push_byte(CH_CR);
        push_byte(CH_LF);
        if (shape < 20) begin
          // Edge sizes; keep the data short, it mostly ends early
          img_w = pick_extreme();
          img_h = pick_extreme();
          cols  = (img_w > 5) ? 5 : img_w;
          rows  = (img_h > 2) ? 2 : img_h;
        end else if (shape < 25) begin
          img_w = $urandom_range(17, 70);
          img_h = $urandom_range(1, 2);
          cols  = img_w;
          rows  = img_h;
        end else begin
          img_w = $urandom_range(1, 4);
          img_h = $urandom_range(1, 4);
          cols  = img_w;
          rows  = img_h;
        end
        push_number(img_w);
        push_byte(CH_SPACE);
        push_number(img_h);
        push_line_end(1'b0);
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            push_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
            if (c + 1 < cols) push_byte(CH_SPACE);
            // Drop the final delimiter now and then: end of file right after the last pixel
            else if (r + 1 < rows || $urandom_range(0, 3) != 0) push_line_end(1'b1);
          end
        end
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)));
      end

      // Break about one file in five: overwrite, drop, insert or cut short
      if ($urandom_range(0, 99) < 20 && file_bytes.size() > 0) begin
        spot = $urandom_range(0, file_bytes.size() - 1);
        stim.op        = OP_BYTE;
        stim.data_byte = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0:       file_bytes[spot] = stim;
          1:       file_bytes.delete(spot);
          2:       file_bytes.insert(spot, stim);
          default: while (file_bytes.size() > spot) void'(file_bytes.pop_back());
        endcase
      end

      stim.op        = OP_EOF;
      stim.data_byte = 8'($urandom_range(0, 255));
      file_bytes.push_back(stim);

      foreach (file_bytes[k]) begin
        send_item(file_bytes[k], found, res);
        if (found) expected_results.push_back(res);
      end
      file_count++;
    end

    // Drain, then give the block time to show any stray result
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/abps_pkg.sv
sv/abps_front.sv
sv/abps_queue.sv
sv/abps_back.sv
sv/ascii_bitmap_stream_parser.sv
sim/tb_top.sv
